>>> rtl/core/swln_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swln_pkg;

    localparam int BONE_W    = 8;
    localparam int WEIGHT_W  = 16;
    localparam int VERTEX_W  = 16;
    // quotient bits of the Q1.15 normalized weight
    localparam int NORM_W    = 16;

    typedef struct packed {
        logic [BONE_W-1:0]   bone;
        logic [WEIGHT_W-1:0] weight;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/swln_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface swln_in_if;
    logic                          valid;
    logic                          ready;
    logic [swln_pkg::BONE_W-1:0]   bone_index;
    logic [swln_pkg::WEIGHT_W-1:0] influence_weight;
    logic                          last_influence;

    modport source (output valid, bone_index, influence_weight, last_influence,
                    input ready);
    modport sink (input valid, bone_index, influence_weight, last_influence,
                  output ready);
endinterface

interface swln_out_if;
    logic                          valid;
    logic                          ready;
    logic [swln_pkg::VERTEX_W-1:0] vertex_number;
    logic [swln_pkg::BONE_W-1:0]   out_bone;
    logic [swln_pkg::NORM_W-1:0]   norm_weight;
    logic                          last_of_vertex;
    logic                          last_of_mesh;

    modport source (output valid, vertex_number, out_bone, norm_weight,
                    last_of_vertex, last_of_mesh, input ready);
    modport sink (input valid, vertex_number, out_bone, norm_weight,
                  last_of_vertex, last_of_mesh, output ready);
endinterface

`default_nettype wire

>>> rtl/core/swln_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module swln_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/skin_weight_limit_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to MAX_INFLUENCES (bone, weight) influences of one vertex in a
// single-port-write, registered-read RAM and emits them, in slot order, with
// each weight divided by the sum of kept weights (floored, Q1.15) when the
// request flagged last_influence arrives. While the store has room a request
// is written into the next free slot. Once it is full, a request starts a
// pass over the RAM that finds the smallest kept weight (lowest slot on a
// tie); the replace state then overwrites that slot if the new weight is
// larger. On the last request each kept entry then gets a RAM read, a load,
// 16 restoring-division steps, an output load and any wait on the result
// channel. One result is registered at the output, so the divider for the
// next entry runs while a finished result waits. A zero weight sum yields
// zero weights. vertex_number counts vertices and last_of_mesh marks the
// last result of vertex vertex_count-1; vertex_count = 0 acts as 65536.
module skin_weight_limit_normalizer #(
    parameter int MAX_INFLUENCES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [swln_pkg::VERTEX_W-1:0] cfg_wdata,
    swln_in_if.sink                            influence,
    swln_out_if.source                         normalized
);

    localparam int IDX_W  = (MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1;
    localparam int CNT_W  = $clog2(MAX_INFLUENCES + 1);
    localparam int SUM_W  = swln_pkg::WEIGHT_W + IDX_W;
    localparam int STEP_W = $clog2(swln_pkg::NORM_W);
    localparam int ENT_W  = $bits(swln_pkg::entry_t);
    localparam int ADDR_W = $clog2(MAX_INFLUENCES > 1 ? MAX_INFLUENCES : 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_REPL = 3'd2;
    localparam logic [2:0] S_ERD  = 3'd3;
    localparam logic [2:0] S_ELD  = 3'd4;
    localparam logic [2:0] S_EDIV = 3'd5;
    localparam logic [2:0] S_EOUT = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic [swln_pkg::VERTEX_W-1:0] vcount_reg, vcount_next;
    logic [swln_pkg::VERTEX_W-1:0] vnum_reg, vnum_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [swln_pkg::BONE_W-1:0]   bone_reg, bone_next;
    logic [swln_pkg::WEIGHT_W-1:0] w_reg, w_next;
    logic                          last_reg, last_next;
    logic [CNT_W-1:0]              scan_reg, scan_next;
    logic                          dv_reg, dv_next;
    logic [IDX_W-1:0]              didx_reg, didx_next;
    logic [swln_pkg::WEIGHT_W-1:0] min_w_reg, min_w_next;
    logic [IDX_W-1:0]              min_slot_reg, min_slot_next;
    logic [CNT_W-1:0]              emit_reg, emit_next;
    logic [SUM_W-1:0]              rem_reg, rem_next;
    logic [swln_pkg::NORM_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [swln_pkg::BONE_W-1:0]   ebone_reg, ebone_next;

    logic                          ovalid_reg, ovalid_next;
    logic [swln_pkg::VERTEX_W-1:0] ovnum_reg, ovnum_next;
    logic [swln_pkg::BONE_W-1:0]   obone_reg, obone_next;
    logic [swln_pkg::NORM_W-1:0]   onorm_reg, onorm_next;
    logic                          olast_reg, olast_next;
    logic                          omesh_reg, omesh_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ENT_W-1:0]      ram_rdata;
    swln_pkg::entry_t      rd_entry;
    swln_pkg::entry_t      wr_entry;

    logic                  accept;
    logic                  full;
    logic                  replace;
    logic                  tail;
    logic                  mesh_end;
    logic                  out_free;
    logic [SUM_W:0]        trial;
    logic                  ge;

    assign accept   = influence.valid && influence.ready;
    assign full     = (count_reg == CNT_W'(MAX_INFLUENCES));
    assign replace  = (state_reg == S_REPL) && (w_reg > min_w_reg);
    assign tail     = ((emit_reg + CNT_W'(1)) == count_reg);
    assign mesh_end = (vnum_reg == (vcount_reg - swln_pkg::VERTEX_W'(1)));
    assign out_free = !ovalid_reg || normalized.ready;
    assign rd_entry = ram_rdata;

    // first division step compares the weight itself, later steps double
    assign trial = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign ge    = (trial >= {1'b0, sum_reg});

    assign influence.ready = (state_reg == S_IDLE);

    always_comb
    begin
        ram_we             = 1'b0;
        ram_waddr          = ADDR_W'(count_reg[IDX_W-1:0]);
        wr_entry.bone      = influence.bone_index;
        wr_entry.weight    = influence.influence_weight;
        if (accept && !full)
        begin
            ram_we = 1'b1;
        end
        else if (replace)
        begin
            ram_we          = 1'b1;
            ram_waddr       = ADDR_W'(min_slot_reg);
            wr_entry.bone   = bone_reg;
            wr_entry.weight = w_reg;
        end
        ram_wdata = wr_entry;
        ram_raddr = (state_reg == S_SCAN) ? ADDR_W'(scan_reg[IDX_W-1:0])
                                          : ADDR_W'(emit_reg[IDX_W-1:0]);
    end

    always_comb
    begin
        state_next    = state_reg;
        vcount_next   = cfg_we ? cfg_wdata : vcount_reg;
        vnum_next     = vnum_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        bone_next     = bone_reg;
        w_next        = w_reg;
        last_next     = last_reg;
        scan_next     = scan_reg;
        dv_next       = 1'b0;
        didx_next     = didx_reg;
        min_w_next    = min_w_reg;
        min_slot_next = min_slot_reg;
        emit_next     = emit_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        step_next     = step_reg;
        ebone_next    = ebone_reg;
        ovalid_next   = ovalid_reg && !normalized.ready;
        ovnum_next    = ovnum_reg;
        obone_next    = obone_reg;
        onorm_next    = onorm_reg;
        olast_next    = olast_reg;
        omesh_next    = omesh_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    bone_next = influence.bone_index;
                    w_next    = influence.influence_weight;
                    last_next = influence.last_influence;
                    emit_next = '0;
                    if (!full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        sum_next   = sum_reg + SUM_W'(influence.influence_weight);
                        state_next = influence.last_influence ? S_ERD : S_IDLE;
                    end
                    else
                    begin
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_reg != CNT_W'(MAX_INFLUENCES))
                begin
                    scan_next = scan_reg + CNT_W'(1);
                    dv_next   = 1'b1;
                    didx_next = scan_reg[IDX_W-1:0];
                end
                if (dv_reg)
                begin
                    // strict less keeps the lowest slot on a tie
                    if ((didx_reg == '0) || (rd_entry.weight < min_w_reg))
                    begin
                        min_w_next    = rd_entry.weight;
                        min_slot_next = didx_reg;
                    end
                    if (didx_reg == IDX_W'(MAX_INFLUENCES - 1))
                    begin
                        state_next = S_REPL;
                    end
                end
            end
            S_REPL:
            begin
                if (replace)
                begin
                    sum_next = sum_reg - SUM_W'(min_w_reg) + SUM_W'(w_reg);
                end
                state_next = last_reg ? S_ERD : S_IDLE;
            end
            S_ERD:
            begin
                state_next = S_ELD;
            end
            S_ELD:
            begin
                rem_next   = SUM_W'(rd_entry.weight);
                ebone_next = rd_entry.bone;
                quo_next   = '0;
                step_next  = '0;
                state_next = S_EDIV;
            end
            S_EDIV:
            begin
                rem_next  = ge ? SUM_W'(trial - {1'b0, sum_reg}) : SUM_W'(trial);
                quo_next  = {quo_reg[swln_pkg::NORM_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(swln_pkg::NORM_W - 1))
                begin
                    state_next = S_EOUT;
                end
            end
            S_EOUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ovnum_next  = vnum_reg;
                    obone_next  = ebone_reg;
                    onorm_next  = (sum_reg == '0) ? '0 : quo_reg;
                    olast_next  = tail;
                    omesh_next  = tail && mesh_end;
                    if (tail)
                    begin
                        count_next = '0;
                        sum_next   = '0;
                        vnum_next  = mesh_end ? '0 : vnum_reg + swln_pkg::VERTEX_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_next  = emit_reg + CNT_W'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            vcount_reg   <= swln_pkg::VERTEX_W'(1);
            vnum_reg     <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            scan_reg     <= '0;
            dv_reg       <= 1'b0;
            emit_reg     <= '0;
            step_reg     <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            vcount_reg   <= vcount_next;
            vnum_reg     <= vnum_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            scan_reg     <= scan_next;
            dv_reg       <= dv_next;
            emit_reg     <= emit_next;
            step_reg     <= step_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bone_reg     <= bone_next;
        w_reg        <= w_next;
        last_reg     <= last_next;
        didx_reg     <= didx_next;
        min_w_reg    <= min_w_next;
        min_slot_reg <= min_slot_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        ebone_reg    <= ebone_next;
        ovnum_reg    <= ovnum_next;
        obone_reg    <= obone_next;
        onorm_reg    <= onorm_next;
        olast_reg    <= olast_next;
        omesh_reg    <= omesh_next;
    end

    assign normalized.valid          = ovalid_reg;
    assign normalized.vertex_number  = ovnum_reg;
    assign normalized.out_bone       = obone_reg;
    assign normalized.norm_weight    = onorm_reg;
    assign normalized.last_of_vertex = olast_reg;
    assign normalized.last_of_mesh   = omesh_reg;

    swln_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_INFLUENCES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire
